// ----- rtl/mwsm_pkg.sv -----
`timescale 1ns / 1ps
// Package: constants, tables and widths shared by the mecanum wheel speed mixer.
package mwsm_pkg;

    // Rotation stages of the sine/cosine pipeline (8 to 24)
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;

    // Internal datapath widths
    localparam int XY_W  = 34;   // CORDIC x/y, Q30 with headroom
    localparam int Z_W   = 33;   // CORDIC residual angle, binary angle units
    localparam int SUM_W = 40;   // wheel sums, 2^-24 cm/s units

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVER_ARM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_GAIN = 2'd2;

    // Register reset values
    localparam logic [14:0] MAX_SPEED_RST  = 15'd15360;
    localparam logic [11:0] LEVER_ARM_RST  = 12'd655;
    localparam logic [15:0] WHEEL_GAIN_RST = 16'd2933;

    // Full turn in centidegrees
    localparam logic signed [18:0] FULL_TURN_CDEG = 19'sd36000;

    // bam = a * 2^32 / 36000 = a * 2^27 / 1125 = a*BAM_Q + floor(a*BAM_R / 1125)
    localparam logic [16:0] BAM_Q    = 17'd119304;
    localparam logic [9:0]  BAM_R    = 10'd728;
    localparam logic [10:0] DIV_C    = 11'd1125;
    // floor(2^36 / 1125); quotient estimate is low by at most one
    localparam logic [25:0] RECIP_M  = 26'd61083979;
    localparam int          RECIP_SH = 36;

    // CORDIC start vector (gain compensated, Q30) and quadrant limits
    localparam logic signed [XY_W-1:0] CORDIC_K_Q30 = 34'sd652032874;
    localparam logic signed [Z_W-1:0]  QUARTER_TURN = 33'sd1073741824;
    localparam logic signed [Z_W-1:0]  HALF_TURN    = 33'sd2147483648;

    // mm * centideg/s to 1/256 cm/s, Q32
    localparam logic signed [25:0] ROT_K_Q32 = 26'sd19190098;

    // Rounding offset of the gain product (one half in Q32)
    localparam logic signed [56:0] GAIN_RND = 57'sd2147483648;

    // Output saturation limits
    localparam logic signed [24:0] RATE_MAX = 25'sd32767;
    localparam logic signed [24:0] RATE_MIN = -25'sd32768;

    // atan(2^-i) in binary angle units (2^32 per turn)
    localparam logic [29:0] ATAN_BAM [ATAN_ENTRIES] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2F9,
        30'h0000517C, 30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
        30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051
    };

    // Side data that rides along the CORDIC stages
    typedef struct packed {
        logic                    flip;
        logic signed [15:0]      speed;
        logic signed [SUM_W-1:0] rot;
    } t_side;

endpackage

// ----- rtl/mecanum_wheel_speed_mixer.sv -----
`timescale 1ns / 1ps
// Mecanum wheel speed mixer: drive command in, four saturated wheel rates out.
//
// Usage:
//   A request (heading, speed, turn) is taken at a rising edge with start high
//   and busy low. busy is low whenever reset is released, so a request may be
//   issued in every cycle. Each result shows on the o_*_rate ports for exactly
//   one cycle with o_valid high; results come out in request order.
//   Throughput: one request per cycle, with busy low outside reset. The
//   pipeline is made of four stages of angle reduction and binary angle
//   conversion, a quadrant fold, one register per CORDIC rotation, then the
//   speed multiply, wheel sums, gain multiply and round/saturate stages.
//   Configuration (max_speed, lever_arm_mm, wheel_gain) is written through
//   i_cfg_we/i_cfg_idx/i_cfg_data while no request is in flight.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   register defaults; no request is taken while reset is held.
//   The receiver cannot stall: o_valid is a one-cycle strobe.
module mecanum_wheel_speed_mixer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_cfg_we,
    input  logic [mwsm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mwsm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [16:0]                    i_heading_cdeg,
    input  logic signed [15:0]                    i_speed_q8,
    input  logic signed [16:0]                    i_turn_cdeg,
    output logic                                  o_valid,
    output logic signed [15:0]                    o_front_right_rate,
    output logic signed [15:0]                    o_front_left_rate,
    output logic signed [15:0]                    o_back_left_rate,
    output logic signed [15:0]                    o_back_right_rate
);

    localparam int N = mwsm_pkg::CORDIC_STAGES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [14:0] r_max_speed;
    logic [11:0] r_lever_arm;
    logic [15:0] r_wheel_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed  <= mwsm_pkg::MAX_SPEED_RST;
            r_lever_arm  <= mwsm_pkg::LEVER_ARM_RST;
            r_wheel_gain <= mwsm_pkg::WHEEL_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mwsm_pkg::CFG_MAX_SPEED:  r_max_speed  <= i_cfg_data[14:0];
                mwsm_pkg::CFG_LEVER_ARM:  r_lever_arm  <= i_cfg_data[11:0];
                mwsm_pkg::CFG_WHEEL_GAIN: r_wheel_gain <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Pipeline never back-pressures; only reset holds requests off
    assign busy = ~i_rst_n;

    // ------------------------------------------------------------------
    // Stage 1: negated heading mod 360 deg, speed clamp, lever * turn
    // ------------------------------------------------------------------
    logic signed [17:0] neg_head;
    logic signed [18:0] head_ext;
    logic signed [18:0] a_sel;
    logic signed [16:0] spd_ext;
    logic signed [16:0] max_pos;
    logic signed [16:0] max_neg;
    logic signed [16:0] spd_clamp;
    logic signed [29:0] n_s1_lt;

    assign neg_head = -($signed({i_heading_cdeg[16], i_heading_cdeg}));
    assign head_ext = {neg_head[17], neg_head};

    always_comb begin
        priority if (head_ext >= mwsm_pkg::FULL_TURN_CDEG) begin
            a_sel = head_ext - mwsm_pkg::FULL_TURN_CDEG;
        end else if (head_ext >= 19'sd0) begin
            a_sel = head_ext;
        end else if (head_ext >= -mwsm_pkg::FULL_TURN_CDEG) begin
            a_sel = head_ext + mwsm_pkg::FULL_TURN_CDEG;
        end else begin
            a_sel = head_ext + (mwsm_pkg::FULL_TURN_CDEG <<< 1);
        end
    end

    assign spd_ext = {i_speed_q8[15], i_speed_q8};
    assign max_pos = $signed({2'b00, r_max_speed});
    assign max_neg = -max_pos;

    always_comb begin
        priority if (spd_ext > max_pos) begin
            spd_clamp = max_pos;
        end else if (spd_ext < max_neg) begin
            spd_clamp = max_neg;
        end else begin
            spd_clamp = spd_ext;
        end
    end

    assign n_s1_lt = $signed({1'b0, r_lever_arm}) * i_turn_cdeg;

    logic               r_s1_valid;
    logic [15:0]        r_s1_a;
    logic signed [15:0] r_s1_speed;
    logic signed [29:0] r_s1_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_a     <= a_sel[15:0];
        r_s1_speed <= spd_clamp[15:0];
        r_s1_lt    <= n_s1_lt;
    end

    // ------------------------------------------------------------------
    // Stage 2: split a*2^27/1125 into a*Q + a*R/1125; rotation product
    // ------------------------------------------------------------------
    logic [25:0]        n_s2_x;
    logic [32:0]        n_s2_p;
    logic signed [55:0] n_s2_rot;

    assign n_s2_x   = r_s1_a * mwsm_pkg::BAM_R;
    assign n_s2_p   = r_s1_a * mwsm_pkg::BAM_Q;
    assign n_s2_rot = r_s1_lt * mwsm_pkg::ROT_K_Q32;

    logic                          r_s2_valid;
    logic [24:0]                   r_s2_x;
    logic [31:0]                   r_s2_p;
    logic signed [15:0]            r_s2_speed;
    logic signed [mwsm_pkg::SUM_W-1:0] r_s2_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_x     <= n_s2_x[24:0];
        r_s2_p     <= n_s2_p[31:0];
        r_s2_speed <= r_s1_speed;
        r_s2_rot   <= n_s2_rot[55:16];
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient estimate by reciprocal multiply
    // ------------------------------------------------------------------
    logic [50:0] n_s3_qfull;

    assign n_s3_qfull = r_s2_x * mwsm_pkg::RECIP_M;

    logic                          r_s3_valid;
    logic [14:0]                   r_s3_q0;
    logic [24:0]                   r_s3_x;
    logic [31:0]                   r_s3_p;
    logic signed [15:0]            r_s3_speed;
    logic signed [mwsm_pkg::SUM_W-1:0] r_s3_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_q0    <= n_s3_qfull[50:mwsm_pkg::RECIP_SH];
        r_s3_x     <= r_s2_x;
        r_s3_p     <= r_s2_p;
        r_s3_speed <= r_s2_speed;
        r_s3_rot   <= r_s2_rot;
    end

    // ------------------------------------------------------------------
    // Stage 4: correct the quotient by one, assemble the binary angle
    // ------------------------------------------------------------------
    logic [25:0] qc;
    logic [25:0] rem;
    logic        corr;
    logic [14:0] q_fix;
    logic [31:0] n_s4_bam;

    assign qc       = r_s3_q0 * mwsm_pkg::DIV_C;
    assign rem      = {1'b0, r_s3_x} - qc;
    assign corr     = (rem >= {15'b0, mwsm_pkg::DIV_C});
    assign q_fix    = r_s3_q0 + {14'b0, corr};
    assign n_s4_bam = r_s3_p + {17'b0, q_fix};

    logic                          r_s4_valid;
    logic [31:0]                   r_s4_bam;
    logic signed [15:0]            r_s4_speed;
    logic signed [mwsm_pkg::SUM_W-1:0] r_s4_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_bam   <= n_s4_bam;
        r_s4_speed <= r_s3_speed;
        r_s4_rot   <= r_s3_rot;
    end

    // ------------------------------------------------------------------
    // Stage 5: fold the angle into [-90, +90] deg, load the CORDIC
    // ------------------------------------------------------------------
    logic signed [mwsm_pkg::Z_W-1:0] z_raw;
    logic signed [mwsm_pkg::Z_W-1:0] z_fold;
    logic                            fold_flip;

    assign z_raw = $signed({r_s4_bam[31], r_s4_bam});

    always_comb begin
        priority if (z_raw > mwsm_pkg::QUARTER_TURN) begin
            z_fold    = mwsm_pkg::HALF_TURN - z_raw;
            fold_flip = 1'b1;
        end else if (z_raw < -mwsm_pkg::QUARTER_TURN) begin
            z_fold    = -mwsm_pkg::HALF_TURN - z_raw;
            fold_flip = 1'b1;
        end else begin
            z_fold    = z_raw;
            fold_flip = 1'b0;
        end
    end

    logic                               r_cv   [N+1];
    logic signed [mwsm_pkg::XY_W-1:0]   r_cx   [N+1];
    logic signed [mwsm_pkg::XY_W-1:0]   r_cy   [N+1];
    logic signed [mwsm_pkg::Z_W-1:0]    r_cz   [N+1];
    mwsm_pkg::t_side                    r_side [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else begin
            r_cv[0] <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx[0]         <= mwsm_pkg::CORDIC_K_Q30;
        r_cy[0]         <= '0;
        r_cz[0]         <= z_fold;
        r_side[0].flip  <= fold_flip;
        r_side[0].speed <= r_s4_speed;
        r_side[0].rot   <= r_s4_rot;
    end

    // ------------------------------------------------------------------
    // CORDIC rotation stages, one register per iteration
    // ------------------------------------------------------------------
    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [mwsm_pkg::XY_W-1:0] dx;
        logic signed [mwsm_pkg::XY_W-1:0] dy;
        logic signed [mwsm_pkg::Z_W-1:0]  ang;

        assign dx  = r_cy[i] >>> i;
        assign dy  = r_cx[i] >>> i;
        assign ang = $signed({3'b000, mwsm_pkg::ATAN_BAM[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else begin
                r_cv[i+1] <= r_cv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!r_cz[i][mwsm_pkg::Z_W-1]) begin
                r_cx[i+1] <= r_cx[i] - dx;
                r_cy[i+1] <= r_cy[i] + dy;
                r_cz[i+1] <= r_cz[i] - ang;
            end else begin
                r_cx[i+1] <= r_cx[i] + dx;
                r_cy[i+1] <= r_cy[i] - dy;
                r_cz[i+1] <= r_cz[i] + ang;
            end
            r_side[i+1] <= r_side[i];
        end
    end

    // ------------------------------------------------------------------
    // Velocity stage: vx = sin*speed, vy = cos*speed, Q30 -> 2^-24 cm/s
    // ------------------------------------------------------------------
    logic signed [mwsm_pkg::XY_W-1:0] sn;
    logic signed [mwsm_pkg::XY_W-1:0] cs;
    logic signed [49:0]               vx_full;
    logic signed [49:0]               vy_full;

    assign sn      = r_cy[N];
    assign cs      = r_side[N].flip ? -r_cx[N] : r_cx[N];
    assign vx_full = sn * r_side[N].speed;
    assign vy_full = cs * r_side[N].speed;

    logic                              r_v_valid;
    logic signed [mwsm_pkg::SUM_W-1:0] r_vx;
    logic signed [mwsm_pkg::SUM_W-1:0] r_vy;
    logic signed [mwsm_pkg::SUM_W-1:0] r_v_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_valid <= 1'b0;
        end else begin
            r_v_valid <= r_cv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_vx    <= {{4{vx_full[49]}}, vx_full[49:14]};
        r_vy    <= {{4{vy_full[49]}}, vy_full[49:14]};
        r_v_rot <= r_side[N].rot;
    end

    // ------------------------------------------------------------------
    // Wheel sums; back wheels negated for the motor wiring
    // ------------------------------------------------------------------
    logic                              r_sum_valid;
    logic signed [mwsm_pkg::SUM_W-1:0] r_sum [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else begin
            r_sum_valid <= r_v_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum[0] <= r_vx + r_vy + r_v_rot;     // front right
        r_sum[1] <= r_vx - r_vy - r_v_rot;     // front left
        r_sum[2] <= r_v_rot - r_vx - r_vy;     // back left
        r_sum[3] <= r_vy - r_vx - r_v_rot;     // back right
    end

    // ------------------------------------------------------------------
    // Gain multiply, then round half up and saturate to 16 bits
    // ------------------------------------------------------------------
    logic signed [16:0] gain_s;

    assign gain_s = $signed({1'b0, r_wheel_gain});

    logic               r_g_valid;
    logic signed [56:0] r_prod [4];
    logic               r_out_valid;
    logic signed [15:0] r_rate [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_g_valid   <= r_sum_valid;
            r_out_valid <= r_g_valid;
        end
    end

    for (genvar w = 0; w < 4; w++) begin : g_wheel
        logic signed [56:0] n_prod;
        logic signed [56:0] rnd;
        logic signed [24:0] q_rate;
        logic signed [15:0] n_rate;

        assign n_prod = r_sum[w] * gain_s;
        assign rnd    = r_prod[w] + mwsm_pkg::GAIN_RND;
        assign q_rate = rnd[56:32];

        always_comb begin
            priority if (q_rate > mwsm_pkg::RATE_MAX) begin
                n_rate = 16'sh7FFF;
            end else if (q_rate < mwsm_pkg::RATE_MIN) begin
                n_rate = 16'sh8000;
            end else begin
                n_rate = q_rate[15:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_prod[w] <= n_prod;
            r_rate[w] <= n_rate;
        end
    end

    // Result ports
    assign o_valid            = r_out_valid;
    assign o_front_right_rate = r_rate[0];
    assign o_front_left_rate  = r_rate[1];
    assign o_back_left_rate   = r_rate[2];
    assign o_back_right_rate  = r_rate[3];

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the mecanum wheel speed mixer: directed table, then random requests.
module tb_top;

    // Timing and run control
    localparam int PIPE_LATENCY = 9 + mwsm_pkg::CORDIC_STAGES;
    localparam int STALL_LIMIT  = 1000;
    localparam int SEG_ITEMS    = 210;
    localparam logic [mwsm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Fixed point constants of the mixer math
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam longint QUARTER_BAM     = 64'sd1073741824;
    localparam longint HALF_BAM        = 64'sd2147483648;
    localparam longint ROT_SCALE_Q32   = 64'sd19190098;
    localparam longint GAIN_HALF_LSB   = 64'sd2147483648;

    typedef struct packed {
        logic signed [15:0] fr;
        logic signed [15:0] fl;
        logic signed [15:0] bl;
        logic signed [15:0] br;
    } t_wheel_rates;

    typedef enum {ROW_CMD, ROW_CFG} t_row_kind;

    // CMD: a/b/c = heading/speed/turn; CFG: a = register index, b = data
    typedef struct {
        t_row_kind kind;
        int        a;
        int        b;
        int        c;
        bit        typed;
        int        e_fr;
        int        e_fl;
        int        e_bl;
        int        e_br;
    } t_row;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic                                 i_cfg_we = 1'b0;
    logic [mwsm_pkg::CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [mwsm_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic signed [16:0]                   i_heading_cdeg = '0;
    logic signed [15:0]                   i_speed_q8 = '0;
    logic signed [16:0]                   i_turn_cdeg = '0;
    logic                                 o_valid;
    logic signed [15:0]                   o_front_right_rate;
    logic signed [15:0]                   o_front_left_rate;
    logic signed [15:0]                   o_back_left_rate;
    logic signed [15:0]                   o_back_right_rate;

    // Register mirror used by the rate predictor
    longint cfg_max_speed = longint'(mwsm_pkg::MAX_SPEED_RST);
    longint cfg_lever_mm  = longint'(mwsm_pkg::LEVER_ARM_RST);
    longint cfg_gain      = longint'(mwsm_pkg::WHEEL_GAIN_RST);

    t_wheel_rates pending_rates [$];
    int           errors = 0;
    int           stall_cycles = 0;

    // atan(2^-i) in binary angle units, 2^32 per turn
    longint atan_steps [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    // Directed requests and register writes; typed rows carry an expectation read off directly
    t_row plan [28] = '{
        '{ROW_CMD, 0, 0, 0, 1, 0, 0, 0, 0},
        '{ROW_CMD, 36000, 0, 0, 1, 0, 0, 0, 0},
        '{ROW_CMD, -36000, 0, 0, 1, 0, 0, 0, 0},
        '{ROW_CMD, 0, 15360, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, 9000, 15360, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, 18000, -15360, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, -9000, 10000, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, 27000, 15360, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, 65535, 32767, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, -65536, -32768, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, 4500, 1000, 36000, 0, 0, 0, 0, 0},
        '{ROW_CMD, 0, 0, -36000, 0, 0, 0, 0, 0},
        '{ROW_CMD, 0, 0, 65535, 0, 0, 0, 0, 0},
        '{ROW_CMD, 0, 0, -65536, 0, 0, 0, 0, 0},
        '{ROW_CFG, mwsm_pkg::CFG_WHEEL_GAIN, 65535, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, mwsm_pkg::CFG_LEVER_ARM, 4095, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, 0, 0, 36000, 1, 32767, -32768, 32767, -32768},
        '{ROW_CMD, 0, 0, -36000, 1, -32768, 32767, -32768, 32767},
        '{ROW_CFG, mwsm_pkg::CFG_MAX_SPEED, 32767, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, 13500, -32768, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, -4500, 32767, 65535, 0, 0, 0, 0, 0},
        '{ROW_CFG, mwsm_pkg::CFG_MAX_SPEED, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, 4500, 32767, 0, 1, 0, 0, 0, 0},
        '{ROW_CFG, CFG_UNUSED, 65535, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, mwsm_pkg::CFG_WHEEL_GAIN, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, mwsm_pkg::CFG_LEVER_ARM, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, mwsm_pkg::CFG_MAX_SPEED, 32767, 0, 0, 0, 0, 0, 0},
        '{ROW_CMD, -13500, 32767, 36000, 1, 0, 0, 0, 0}
    };

    mecanum_wheel_speed_mixer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_heading_cdeg     (i_heading_cdeg),
        .i_speed_q8         (i_speed_q8),
        .i_turn_cdeg        (i_turn_cdeg),
        .o_valid            (o_valid),
        .o_front_right_rate (o_front_right_rate),
        .o_front_left_rate  (o_front_left_rate),
        .o_back_left_rate   (o_back_left_rate),
        .o_back_right_rate  (o_back_right_rate)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Wheel gain, round half up, saturate to 16 bits
    function automatic logic signed [15:0] gain_round_sat(input longint sum);
        longint p;
        p = (sum * cfg_gain + GAIN_HALF_LSB) >>> 32;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[15:0];
    endfunction

    // Expected wheel rates for one drive command under the current registers
    function automatic t_wheel_rates mix_wheel_rates(input logic signed [16:0] hdg,
                                                     input logic signed [15:0] spd,
                                                     input logic signed [16:0] trn);
        longint sp, ang, z, x, y, dx, dy, cs, vx, vy, rot;
        bit flip;
        t_wheel_rates res;
        sp = longint'(spd);
        if (sp > cfg_max_speed) sp = cfg_max_speed;
        if (sp < -cfg_max_speed) sp = -cfg_max_speed;
        // negate heading, wrap into one turn, convert to binary angle
        ang = (-longint'(hdg)) % 64'sd36000;
        if (ang < 0) ang += 36000;
        z = (ang << 32) / 36000;
        if (z >= HALF_BAM) z -= 2 * HALF_BAM;
        // fold into +-90 degrees; cosine changes sign
        flip = 1'b0;
        if (z > QUARTER_BAM) begin
            z = HALF_BAM - z;
            flip = 1'b1;
        end else if (z < -QUARTER_BAM) begin
            z = -HALF_BAM - z;
            flip = 1'b1;
        end
        x = CORDIC_GAIN_Q30;
        y = 0;
        for (int i = 0; i < mwsm_pkg::CORDIC_STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_steps[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_steps[i];
            end
        end
        cs = flip ? -x : x;
        vx = (y * sp) >>> 14;
        vy = (cs * sp) >>> 14;
        rot = (cfg_lever_mm * longint'(trn) * ROT_SCALE_Q32) >>> 16;
        res.fr = gain_round_sat(vx + vy + rot);
        res.fl = gain_round_sat(vx - vy - rot);
        res.bl = gain_round_sat(-(vx + vy - rot));
        res.br = gain_round_sat(-(vx - vy + rot));
        return res;
    endfunction

    // Issue one request, idling first with the given odds
    task automatic send_request(input logic signed [16:0] hdg, input logic signed [15:0] spd,
                                input logic signed [16:0] trn, input int gap_pct,
                                input bit typed, input t_wheel_rates typed_rates);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_heading_cdeg <= hdg;
        i_speed_q8     <= spd;
        i_turn_cdeg    <= trn;
        do @(posedge i_clk); while (busy);
        pending_rates.push_back(typed ? typed_rates : mix_wheel_rates(hdg, spd, trn));
    endtask

    // Register write once the pipeline has drained; start must already be low
    task automatic write_reg(input logic [mwsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        while (pending_rates.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            mwsm_pkg::CFG_MAX_SPEED:  cfg_max_speed = longint'(data[14:0]);
            mwsm_pkg::CFG_LEVER_ARM:  cfg_lever_mm  = longint'(data[11:0]);
            mwsm_pkg::CFG_WHEEL_GAIN: cfg_gain      = longint'(data);
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Zero, all ones, or random
    function automatic logic [15:0] extreme_pick();
        case ($urandom_range(2))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic check_rate(input string name, input logic signed [15:0] want,
                              input logic signed [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_wheel_rates want;
        if (i_rst_n && o_valid) begin
            if (pending_rates.size() == 0) begin
                $error("result with no request pending");
                errors++;
            end else begin
                want = pending_rates.pop_front();
                check_rate("front_right_rate", want.fr, o_front_right_rate);
                check_rate("front_left_rate", want.fl, o_front_left_rate);
                check_rate("back_left_rate", want.bl, o_back_left_rate);
                check_rate("back_right_rate", want.br, o_back_right_rate);
            end
        end
    end

    // Watchdog on cycles with no accepted request and no result
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        int                 idle_pct, m, v;
        logic signed [16:0] hdg, trn;
        logic signed [15:0] spd;
        t_wheel_rates       typed_rates;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int k = 0; k < 28; k++) begin
            if (plan[k].kind == ROW_CFG) begin
                start <= 1'b0;
                write_reg(plan[k].a[mwsm_pkg::CFG_IDX_W-1:0], plan[k].b[15:0]);
            end else begin
                typed_rates.fr = plan[k].e_fr[15:0];
                typed_rates.fl = plan[k].e_fl[15:0];
                typed_rates.bl = plan[k].e_bl[15:0];
                typed_rates.br = plan[k].e_br[15:0];
                send_request(plan[k].a[16:0], plan[k].b[15:0], plan[k].c[16:0], 0,
                             plan[k].typed, typed_rates);
            end
        end

        // random segments: three idle settings, three register settings each
        for (int seg = 0; seg < 9; seg++) begin
            idle_pct = (seg < 3) ? 14 : (seg < 6) ? 54 : 0;
            start <= 1'b0;
            case (seg % 3)
                0: begin
                    write_reg(mwsm_pkg::CFG_MAX_SPEED, 16'(mwsm_pkg::MAX_SPEED_RST));
                    write_reg(mwsm_pkg::CFG_LEVER_ARM, 16'(mwsm_pkg::LEVER_ARM_RST));
                    write_reg(mwsm_pkg::CFG_WHEEL_GAIN, 16'(mwsm_pkg::WHEEL_GAIN_RST));
                end
                1: begin
                    write_reg(mwsm_pkg::CFG_MAX_SPEED, 16'($urandom_range(65535)));
                    write_reg(mwsm_pkg::CFG_LEVER_ARM, 16'($urandom_range(65535)));
                    write_reg(mwsm_pkg::CFG_WHEEL_GAIN, 16'($urandom_range(65535)));
                end
                default: begin
                    write_reg(mwsm_pkg::CFG_MAX_SPEED, extreme_pick());
                    write_reg(mwsm_pkg::CFG_LEVER_ARM, extreme_pick());
                    write_reg(mwsm_pkg::CFG_WHEEL_GAIN, extreme_pick());
                end
            endcase
            for (int n = 0; n < SEG_ITEMS; n++) begin
                // heading: mostly one turn either way, some quadrant edges, some raw
                case ($urandom_range(9))
                    0: v = int'($urandom);
                    1: v = int'($urandom_range(8)) * 9000 - 36000;
                    default: v = int'($urandom_range(72000)) - 36000;
                endcase
                hdg = v[16:0];
                // speed: raw, near the clamp, or within the clamp
                m = int'(cfg_max_speed);
                case ($urandom_range(7))
                    0, 1: v = int'($urandom);
                    2: begin
                        v = m + int'($urandom_range(4)) - 2;
                        if ($urandom_range(1) == 0) v = -v;
                    end
                    default: v = int'($urandom_range(2 * m)) - m;
                endcase
                spd = v[15:0];
                // turn: mostly in range, some raw
                if ($urandom_range(7) == 0) v = int'($urandom);
                else v = int'($urandom_range(72000)) - 36000;
                trn = v[16:0];
                send_request(hdg, spd, trn, idle_pct, 1'b0, '0);
            end
        end
        start <= 1'b0;

        // drain, then let any stray result show up
        while (pending_rates.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
